FILE: hdl/mavb_pkg.sv
// shared constants, types and helper functions for the moving average bar graph
package mavb_pkg;

   localparam int WINDOW    = 50;
   localparam int SAMPLE_W  = 10;
   localparam int LEVEL_W   = 8;
   localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
   localparam int DIV_W     = SUM_W - 2;
   localparam int STEP_W    = $clog2(DIV_W + 1);

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_UPD  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_RUN  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [DIV_W-1:0] q);
      logic over;
      over = 1'b0;
      for (int i = LEVEL_W; i < DIV_W; i++) begin
         over = over | q[i];
      end
      clamp_level = over ? {LEVEL_W{1'b1}} : q[LEVEL_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] bar_pattern(input logic [LEVEL_W-1:0] lvl);
      logic [2:0]         top;
      logic [LEVEL_W-1:0] mask;
      top  = lvl[LEVEL_W-1:LEVEL_W-3];
      mask = '0;
      for (int j = 0; j < LEVEL_W; j++) begin
         mask[j] = (3'(j) <= top);
      end
      bar_pattern = (lvl == '0) ? '0 : mask;
   endfunction

endpackage

FILE: hdl/mavb_req_if.sv
// sample channel interface
interface mavb_req_if;
   import mavb_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

FILE: hdl/mavb_rsp_if.sv
// level and bar pattern channel interface
interface mavb_rsp_if;
   import mavb_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic [LEVEL_W-1:0] bar_mask;

   modport source (output valid, output level, output bar_mask, input ready);
   modport sink   (input valid, input level, input bar_mask, output ready);
endinterface

FILE: hdl/mavb_ring.sv
// sample history ring with running sum, write index and fill count
module mavb_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  mavb_pkg::ring_ctrl_type       ctrl,
   input  logic [mavb_pkg::SAMPLE_W-1:0] sample,
   output logic [mavb_pkg::SUM_W-1:0]    sum,
   output logic [mavb_pkg::CNT_W-1:0]    count
);
   import mavb_pkg::*;

   logic [SAMPLE_W-1:0] mem [WINDOW];
   logic [SAMPLE_W-1:0] old_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [IDX_W-1:0]    idx_ff,   idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff,   sum_in;
   logic                full;

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         old_ff    <= mem[idx_ff];
         sample_ff <= sample;
      end
      if (ctrl.wr_en) begin
         mem[idx_ff] <= sample_ff;
      end
   end

   assign full = (count_ff == CNT_W'(WINDOW));

   always_comb begin
      idx_in   = (idx_ff == IDX_W'(WINDOW - 1)) ? '0 : idx_ff + 1'b1;
      count_in = full ? count_ff : count_ff + 1'b1;
      sum_in   = sum_ff - (full ? SUM_W'(old_ff) : '0) + SUM_W'(sample_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (ctrl.wr_en) begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign sum   = sum_ff;
   assign count = count_ff;
endmodule

FILE: hdl/mavb_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module mavb_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mavb_pkg::DIV_W-1:0]  dividend,
   input  logic [mavb_pkg::CNT_W-1:0]  divisor,
   output logic [mavb_pkg::DIV_W-1:0]  quotient,
   output mavb_pkg::div_stat_type      stat
);
   import mavb_pkg::*;

   logic [CNT_W-1:0]  rem_ff,  rem_in;
   logic [DIV_W-1:0]  quo_ff,  quo_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    trial;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
      rem_in  = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_in  = {quo_ff[DIV_W-2:0], fits};
      step_in = step_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (step_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         step_ff <= STEP_W'(DIV_W);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (step_ff == STEP_W'(1));
         if (step_ff != '0) begin
            step_ff <= step_in;
         end
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = (step_ff != '0);
   assign stat.done = done_ff;
endmodule

FILE: hdl/moving_average_led_bargraph_core.sv
// top level: boxcar moving average of light samples driving an eight-led bar graph
//
// req_if carries one 10-bit sample per transaction (valid/ready). Each sample
// enters a 50-entry history ring; the running sum over the filled entries is
// divided by four times the fill count to give an 8-bit level, and bar_mask
// lights leds 0 through level/32 (all dark at level 0). rsp_if returns one
// level/bar_mask transaction per sample, in order.
// One sample is processed at a time: the ring is read and then updated, the
// bit-serial divider then produces one quotient bit per cycle for each of the
// 14 dividend bits at a 50-entry window, and a new sample is taken only once
// the previous result has moved into the output register.
// The result sits in an output register; a stalled receiver does not stop the
// next sample from being accepted and worked on, but that sample's result
// waits in the divider until the register frees up.
// Synchronous reset empties the ring (fill count, sum and write index go to
// zero) and drops any pending result.
module moving_average_led_bargraph_core (
   input  logic       clock,
   input  logic       reset,
   mavb_req_if.sink   req_if,
   mavb_rsp_if.source rsp_if
);
   import mavb_pkg::*;

   state_type          state_ff, state_in;
   ring_ctrl_type      ring_ctrl;
   div_stat_type       div_stat;
   logic [SUM_W-1:0]   sum;
   logic [CNT_W-1:0]   count;
   logic [DIV_W-1:0]   quotient;
   logic [LEVEL_W-1:0] level;
   logic               out_valid_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] mask_ff;
   logic               accept;
   logic               load_out;

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign accept        = req_if.valid & req_if.ready;
   assign load_out      = (state_ff == ST_DONE) & (~out_valid_ff | rsp_if.ready);
   assign ring_ctrl.rd_en = accept;
   assign ring_ctrl.wr_en = (state_ff == ST_UPD);

   mavb_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ring_ctrl),
      .sample (req_if.sample),
      .sum    (sum),
      .count  (count)
   );

   mavb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_LOAD),
      .dividend (sum[SUM_W-1:2]),
      .divisor  (count),
      .quotient (quotient),
      .stat     (div_stat)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_UPD;
         ST_UPD:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_RUN;
         ST_RUN:  if (div_stat.done && !div_stat.busy) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign level = clamp_level(quotient);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         level_ff <= level;
         mask_ff  <= bar_pattern(level);
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.level    = level_ff;
   assign rsp_if.bar_mask = mask_ff;
endmodule
